>>> src/bmhq_pkg.sv
// ============================================================================
// bmhq_pkg
// Shared types, codes and helpers for the binary min-heap queue.
// ============================================================================
`default_nettype none

package bmhq_pkg;

    localparam int DATA_W = 16;
    localparam int CNT_W  = 8;
    localparam int LVL_W  = 3;

    // Result value of a delete or peek on an empty queue
    localparam logic [DATA_W-1:0] EMPTY_MARK = 16'h8001;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_PEEK   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_FETCH,
        ST_RUN,
        ST_RESP
    } t_state;

    typedef enum logic {
        TOK_INS,
        TOK_DEL
    } t_tok_op;

    // Work token moving down the chain of level cells.
    // insert: num = target slot, lvl = level of that slot, val = carried value
    // delete: num = count after removal, idx = parent slot, val = old last entry
    typedef struct packed {
        logic              valid;
        t_tok_op           op;
        logic [CNT_W-1:0]  num;
        logic [LVL_W-1:0]  lvl;
        logic [CNT_W-1:0]  idx;
        logic [DATA_W-1:0] val;
    } t_tok;

    // Write request sent from a cell to the cell one level up
    typedef struct packed {
        logic              en;
        logic [CNT_W-1:0]  idx;
        logic [DATA_W-1:0] val;
    } t_wb;

    // Broadcast read of the root and of one slot by global index
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] gidx;
    } t_probe;

    // Heap level of a 1-based slot index (floor of log2)
    function automatic logic [LVL_W-1:0] f_level(input logic [CNT_W-1:0] g);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int b = 1; b < CNT_W; b++) begin
            if (g[b]) begin
                r = LVL_W'(b);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/bmhq_ram.sv
// ============================================================================
// bmhq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
`default_nettype none

module bmhq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_ra_addr,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rb_addr,
    output logic      [WIDTH-1:0]                      o_ra_data,
    output logic      [WIDTH-1:0]                      o_rb_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_ra_data <= r_mem[i_ra_addr];
        o_rb_data <= r_mem[i_rb_addr];
    end

endmodule

`default_nettype wire

>>> src/bmhq_cell.sv
// ============================================================================
// bmhq_cell
// One heap level: owns the slots of level K and does one read-compare-write
// step of an insert or delete token before passing it to the next level.
// ============================================================================
`default_nettype none

module bmhq_cell #(
    parameter int K      = 0,
    parameter int LEVELS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bmhq_pkg::t_tok      i_tok,
    output bmhq_pkg::t_tok           o_tok,
    input  wire bmhq_pkg::t_wb       i_wb,
    output bmhq_pkg::t_wb            o_wb,
    input  wire bmhq_pkg::t_probe    i_probe,
    output logic [bmhq_pkg::DATA_W-1:0] o_root,
    output logic [bmhq_pkg::DATA_W-1:0] o_last,
    output logic                     o_done
);

    localparam int DEPTH = 1 << K;
    localparam int AW    = (K == 0) ? 1 : K;
    localparam logic [bmhq_pkg::CNT_W-1:0] MASK = bmhq_pkg::CNT_W'((1 << K) - 1);
    localparam logic [bmhq_pkg::LVL_W-1:0] KL   = bmhq_pkg::LVL_W'(K);

    // Slot index within this level from a global 1-based slot index
    function automatic logic [AW-1:0] f_loc(input logic [bmhq_pkg::CNT_W-1:0] g);
        return AW'(g & MASK);
    endfunction

    bmhq_pkg::t_tok r_tok;
    bmhq_pkg::t_tok n_out;
    bmhq_pkg::t_tok r_out;

    logic [AW-1:0]                 w_ra_addr;
    logic [AW-1:0]                 w_rb_addr;
    logic [bmhq_pkg::DATA_W-1:0]   w_ra_data;
    logic [bmhq_pkg::DATA_W-1:0]   w_rb_data;
    logic                          w_own_we;
    logic [AW-1:0]                 w_own_addr;
    logic [bmhq_pkg::DATA_W-1:0]   w_own_data;
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [bmhq_pkg::DATA_W-1:0]   w_wdata;

    logic [bmhq_pkg::CNT_W-1:0]    w_in_g;
    logic [bmhq_pkg::CNT_W-1:0]    w_in_kid;
    logic [bmhq_pkg::CNT_W-1:0]    w_g;
    logic [bmhq_pkg::CNT_W-1:0]    w_kid;
    logic [bmhq_pkg::CNT_W-1:0]    w_sel_idx;
    logic [bmhq_pkg::DATA_W-1:0]   w_sel_val;

    // Latch the arriving token; its reads are issued in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_out <= '0;
        end else begin
            r_tok <= i_tok;
            r_out <= n_out;
        end
    end

    assign o_tok  = r_out;
    assign o_root = w_ra_data;
    assign o_last = w_rb_data;

    // Read addresses: probe, insert path slot, or both children of the hole
    always_comb begin
        w_in_g   = i_tok.num >> bmhq_pkg::LVL_W'(i_tok.lvl - KL);
        w_in_kid = {i_tok.idx[bmhq_pkg::CNT_W-2:0], 1'b0};
        if (i_probe.en) begin
            w_ra_addr = '0;
            w_rb_addr = f_loc(i_probe.gidx);
        end else if (i_tok.op == bmhq_pkg::TOK_INS) begin
            w_ra_addr = f_loc(w_in_g);
            w_rb_addr = f_loc(w_in_g);
        end else begin
            w_ra_addr = f_loc(w_in_kid);
            w_rb_addr = f_loc(w_in_kid | bmhq_pkg::CNT_W'(1));
        end
    end

    // Compare step on the read data
    always_comb begin
        n_out      = '0;
        o_wb       = '0;
        o_done     = 1'b0;
        w_own_we   = 1'b0;
        w_own_addr = '0;
        w_own_data = r_tok.val;
        w_g        = r_tok.num >> bmhq_pkg::LVL_W'(r_tok.lvl - KL);
        w_kid      = {r_tok.idx[bmhq_pkg::CNT_W-2:0], 1'b0};
        w_sel_idx  = w_kid;
        w_sel_val  = w_ra_data;
        if (r_tok.valid) begin
            if (r_tok.op == bmhq_pkg::TOK_INS) begin
                w_own_addr = f_loc(w_g);
                if (r_tok.lvl == KL) begin
                    // new slot reached: drop the carried value here
                    w_own_we = 1'b1;
                    o_done   = 1'b1;
                end else begin
                    n_out = r_tok;
                    if ($signed(w_ra_data) > $signed(r_tok.val)) begin
                        w_own_we  = 1'b1;
                        n_out.val = w_ra_data;
                    end
                end
            end else if (K == 0) begin
                // root has no parent: pass the delete on to level one
                n_out = r_tok;
            end else begin
                if (w_kid > r_tok.num) begin
                    // hole has no child: old last entry settles in the hole
                    o_wb   = '{en: 1'b1, idx: r_tok.idx, val: r_tok.val};
                    o_done = 1'b1;
                end else begin
                    if ((w_kid != r_tok.num) && ($signed(w_rb_data) < $signed(w_ra_data)))
                    begin
                        w_sel_idx = w_kid | bmhq_pkg::CNT_W'(1);
                        w_sel_val = w_rb_data;
                    end
                    if ($signed(r_tok.val) > $signed(w_sel_val)) begin
                        // move the smaller child up, hole moves down
                        o_wb = '{en: 1'b1, idx: r_tok.idx, val: w_sel_val};
                        if (K == LEVELS - 1) begin
                            w_own_we   = 1'b1;
                            w_own_addr = f_loc(w_sel_idx);
                            o_done     = 1'b1;
                        end else begin
                            n_out     = r_tok;
                            n_out.idx = w_sel_idx;
                        end
                    end else begin
                        o_wb   = '{en: 1'b1, idx: r_tok.idx, val: r_tok.val};
                        o_done = 1'b1;
                    end
                end
            end
        end
    end

    // Write port: requests from the level below, else own writes
    always_comb begin
        if (i_wb.en) begin
            w_we    = 1'b1;
            w_waddr = f_loc(i_wb.idx);
            w_wdata = i_wb.val;
        end else begin
            w_we    = w_own_we;
            w_waddr = w_own_addr;
            w_wdata = w_own_data;
        end
    end

    bmhq_ram #(
        .WIDTH (bmhq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_ra_addr (w_ra_addr),
        .i_rb_addr (w_rb_addr),
        .o_ra_data (w_ra_data),
        .o_rb_data (w_rb_data)
    );

endmodule

`default_nettype wire

>>> src/bmhq_ctrl.sv
// ============================================================================
// bmhq_ctrl
// Operation sequencer: decodes items, keeps the entry count, launches tokens
// into the level chain and holds the result register.
// ============================================================================
`default_nettype none

module bmhq_ctrl #(
    parameter int LEVELS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_in_op,
    input  wire logic [bmhq_pkg::DATA_W-1:0]   i_in_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [31:0]                        o_out_data,
    input  wire logic [bmhq_pkg::CNT_W-1:0]    i_limit,
    output bmhq_pkg::t_tok                     o_tok,
    output bmhq_pkg::t_probe                   o_probe,
    input  wire logic [bmhq_pkg::DATA_W-1:0]   i_root,
    input  wire logic [bmhq_pkg::DATA_W-1:0]   i_last [LEVELS],
    input  wire logic                          i_done
);

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    bmhq_pkg::t_state            r_state, n_state;
    logic [bmhq_pkg::CNT_W-1:0]  r_count, n_count;
    bmhq_pkg::t_opcode           r_op, n_op;
    logic [bmhq_pkg::DATA_W-1:0] r_res, n_res;
    bmhq_pkg::t_status           r_status, n_status;
    bmhq_pkg::t_tok              r_tok, n_tok;
    logic                        r_out_valid, n_out_valid;
    logic [31:0]                 r_out_data, n_out_data;

    logic                        w_accept;
    bmhq_pkg::t_opcode           w_op;
    logic [bmhq_pkg::CNT_W-1:0]  w_inc;
    logic [bmhq_pkg::CNT_W-1:0]  w_dec;

    assign w_op     = bmhq_pkg::t_opcode'(i_in_op);
    assign w_accept = i_in_valid && o_in_ready;
    assign w_inc    = r_count + bmhq_pkg::CNT_W'(1);
    assign w_dec    = r_count - bmhq_pkg::CNT_W'(1);

    assign o_in_ready  = (r_state == bmhq_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_tok       = r_tok;
    assign o_probe     = '{en: (r_state == bmhq_pkg::ST_PROBE), gidx: r_count};

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmhq_pkg::ST_IDLE;
            r_count     <= '0;
            r_tok       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_tok       <= n_tok;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_res      <= n_res;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    // Next state and outputs
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_res       = r_res;
        n_status    = r_status;
        n_tok       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        case (r_state)
            bmhq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op     = w_op;
                    n_res    = '0;
                    n_status = bmhq_pkg::STS_OK;
                    case (w_op)
                        bmhq_pkg::OP_INSERT: begin
                            if (r_count >= i_limit) begin
                                n_status = bmhq_pkg::STS_FULL;
                                n_state  = bmhq_pkg::ST_RESP;
                            end else begin
                                n_count = w_inc;
                                n_tok   = '{valid: 1'b1, op: bmhq_pkg::TOK_INS, num: w_inc,
                                            lvl: bmhq_pkg::f_level(w_inc), idx: '0,
                                            val: i_in_value};
                                n_state = bmhq_pkg::ST_RUN;
                            end
                        end
                        bmhq_pkg::OP_DELETE, bmhq_pkg::OP_PEEK: begin
                            if (r_count == '0) begin
                                n_res    = bmhq_pkg::EMPTY_MARK;
                                n_status = bmhq_pkg::STS_EMPTY;
                                n_state  = bmhq_pkg::ST_RESP;
                            end else begin
                                n_state = bmhq_pkg::ST_PROBE;
                            end
                        end
                        default: begin
                            n_count = '0;
                            n_state = bmhq_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            bmhq_pkg::ST_PROBE: begin
                n_state = bmhq_pkg::ST_FETCH;
            end
            bmhq_pkg::ST_FETCH: begin
                // root and last entry are on the read ports now
                n_res = i_root;
                if (r_op == bmhq_pkg::OP_DELETE) begin
                    n_count = w_dec;
                    n_tok   = '{valid: 1'b1, op: bmhq_pkg::TOK_DEL, num: w_dec, lvl: '0,
                                idx: bmhq_pkg::CNT_W'(1),
                                val: i_last[LW'(bmhq_pkg::f_level(r_count))]};
                    n_state = bmhq_pkg::ST_RUN;
                end else begin
                    n_state = bmhq_pkg::ST_RESP;
                end
            end
            bmhq_pkg::ST_RUN: begin
                if (i_done) begin
                    n_state = bmhq_pkg::ST_RESP;
                end
            end
            bmhq_pkg::ST_RESP: begin
                // load the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0000, (r_count >= i_limit), (r_count == '0),
                                   r_count, r_status, r_res};
                    n_state     = bmhq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bmhq_pkg::ST_IDLE;
            end
        endcase
    end

    // A cell finishes only while a token is out
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> (r_state == bmhq_pkg::ST_RUN))
        else $error("token finished outside run state");

    // Finish of a token always moves on to the response
    a_run_to_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmhq_pkg::ST_RUN && i_done) |=> (r_state == bmhq_pkg::ST_RESP))
        else $error("finished token did not lead to a response");

endmodule

`default_nettype wire

>>> src/binary_min_heap_queue.sv
// ============================================================================
// binary_min_heap_queue
// Min-priority queue as a binary heap held in a chain of level cells.
// ============================================================================
//
// Channel   Dir  Handshake               Contents (low bit first)
// s_axis    in   s_axis_tvalid/tready    tuser: opcode[1:0]; tdata: value[15:0]
// m_axis    out  m_axis_tvalid/tready    tdata: result_value, status, count,
//                                        is_empty, is_full, zero pad
// apb       in   psel/penable/pwrite     capacity at byte address 0
//
// One item at a time: a new item is taken only after the result of the last
// one is loaded into the output register. An insert passes the levels from
// the root down to the level of the new slot; a delete passes them from the
// root down until the hole settles, at least to level 1; a peek only reads
// the root; a refused insert, an empty delete or peek, and clear use no
// level cell. Each heap level costs a registered RAM read then a compare-and-write.
// Reset empties the queue and sets capacity to 255; slot contents are not
// cleared. A stalled output holds one result; the block still takes one more
// item, runs it and holds its result until the output register frees.
// ============================================================================
`default_nettype none

module binary_min_heap_queue #(
    parameter int MAX_ENTRIES = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // value[15:0]
    input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // result_value[15:0], status[17:16],
                                             // count[25:18], is_empty[26],
                                             // is_full[27], zero[31:28]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int DEPTH  = (MAX_ENTRIES < 255) ? MAX_ENTRIES : 255;
    localparam int LEVELS = $clog2(DEPTH + 1);
    localparam logic [16:0] MAX_L = 17'(MAX_ENTRIES);

    logic [bmhq_pkg::CNT_W-1:0]  r_capacity;
    logic [bmhq_pkg::CNT_W-1:0]  w_limit;

    bmhq_pkg::t_tok              w_tok [LEVELS+1];
    bmhq_pkg::t_wb               w_wb  [LEVELS+1];
    bmhq_pkg::t_probe            w_probe;
    logic [bmhq_pkg::DATA_W-1:0] w_root [LEVELS];
    logic [bmhq_pkg::DATA_W-1:0] w_last [LEVELS];
    logic [LEVELS-1:0]           w_done;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 8'd255;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_capacity <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_capacity};

    // Limit in force: capacity clipped to the storage size
    assign w_limit = ({9'd0, r_capacity} > MAX_L) ? bmhq_pkg::CNT_W'(DEPTH) : r_capacity;

    bmhq_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_op     (s_axis_tuser),
        .i_in_value  (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_limit     (w_limit),
        .o_tok       (w_tok[0]),
        .o_probe     (w_probe),
        .i_root      (w_root[0]),
        .i_last      (w_last),
        .i_done      (|w_done)
    );

    assign w_wb[LEVELS] = '0;

    // Chain of level cells
    for (genvar k = 0; k < LEVELS; k++) begin : g_cell
        bmhq_cell #(
            .K      (k),
            .LEVELS (LEVELS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1]),
            .i_wb    (w_wb[k+1]),
            .o_wb    (w_wb[k]),
            .i_probe (w_probe),
            .o_root  (w_root[k]),
            .o_last  (w_last[k]),
            .o_done  (w_done[k])
        );
    end

    // Only one cell finishes a token at a time
    a_done_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_done))
        else $error("more than one cell finished a token");

    // No token ever runs past the deepest level
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_tok[LEVELS].valid)
        else $error("token left the last level cell");

    // The root cell never requests a write above itself
    a_no_wb_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_wb[0].en)
        else $error("root cell issued a parent write");

endmodule

`default_nettype wire

>>> test/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the binary min-heap priority queue: a short directed
// table, then random phases under several capacities; each result is checked
// against want for typed rows, else against a behavioral heap kept in the bench.
// ============================================================================

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DIR_N       = 25;
    localparam int         LIMIT_CYCLES = 1000000;
    localparam int         END_WAIT    = 40;
    localparam logic [2:0] CAP_ADDR    = 3'd0;

    // One result as the block reports it
    typedef struct packed {
        logic [15:0]       rvalue;
        bmhq_pkg::t_status status;
        logic [7:0]        count;
        logic              is_empty;
        logic              is_full;
    } t_heap_result;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        bmhq_pkg::t_opcode op;
        logic [15:0]       val;
        logic              typed;
        t_heap_result      want;
    } t_dir_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;  // value[15:0]
    logic [1:0]  s_axis_tuser   = '0;  // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [31:0] m_axis_tdata;         // result_value[15:0], status[17:16],
                                       // count[25:18], is_empty[26], is_full[27]
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    // Behavioral copy of the queue
    logic signed [15:0] heap_model [1:255];
    int                 held_count     = 0;
    int                 capacity_model = 255;

    t_heap_result expected_replies [$];
    int           error_count = 0;
    int           cycle_count = 0;

    // Sender burst control
    int burst_left = 0;
    bit no_idle    = 1'b0;

    // Receiver stall control
    int stall_left = 0;
    int rx_mode    = 0;
    int rx_timer   = 0;

    t_dir_row dir_rows [DIR_N] = '{
        '{bmhq_pkg::OP_PEEK,   16'h0000, 1'b1,
          '{bmhq_pkg::EMPTY_MARK, bmhq_pkg::STS_EMPTY, 8'd0, 1'b1, 1'b0}},
        '{bmhq_pkg::OP_DELETE, 16'h7FFF, 1'b1,
          '{bmhq_pkg::EMPTY_MARK, bmhq_pkg::STS_EMPTY, 8'd0, 1'b1, 1'b0}},
        '{bmhq_pkg::OP_INSERT, 16'h7FFF, 1'b1,
          '{16'h0000, bmhq_pkg::STS_OK, 8'd1, 1'b0, 1'b0}},
        '{bmhq_pkg::OP_INSERT, 16'h8000, 1'b1,
          '{16'h0000, bmhq_pkg::STS_OK, 8'd2, 1'b0, 1'b0}},
        '{bmhq_pkg::OP_PEEK,   16'hFFFF, 1'b1,
          '{16'h8000, bmhq_pkg::STS_OK, 8'd2, 1'b0, 1'b0}},
        '{bmhq_pkg::OP_INSERT, 16'h8001, 1'b0, '0},
        '{bmhq_pkg::OP_INSERT, 16'h0000, 1'b0, '0},
        '{bmhq_pkg::OP_INSERT, 16'hFFFF, 1'b0, '0},
        '{bmhq_pkg::OP_INSERT, 16'h5555, 1'b0, '0},
        '{bmhq_pkg::OP_INSERT, 16'hAAAA, 1'b0, '0},
        '{bmhq_pkg::OP_INSERT, 16'h0001, 1'b0, '0},
        '{bmhq_pkg::OP_DELETE, 16'h1234, 1'b0, '0},
        '{bmhq_pkg::OP_DELETE, 16'h0000, 1'b0, '0},
        '{bmhq_pkg::OP_PEEK,   16'h0000, 1'b0, '0},
        '{bmhq_pkg::OP_DELETE, 16'h0000, 1'b0, '0},
        '{bmhq_pkg::OP_CLEAR,  16'hFFFF, 1'b1,
          '{16'h0000, bmhq_pkg::STS_OK, 8'd0, 1'b1, 1'b0}},
        '{bmhq_pkg::OP_DELETE, 16'h0000, 1'b1,
          '{bmhq_pkg::EMPTY_MARK, bmhq_pkg::STS_EMPTY, 8'd0, 1'b1, 1'b0}},
        '{bmhq_pkg::OP_PEEK,   16'h0000, 1'b1,
          '{bmhq_pkg::EMPTY_MARK, bmhq_pkg::STS_EMPTY, 8'd0, 1'b1, 1'b0}},
        '{bmhq_pkg::OP_INSERT, 16'd100,  1'b0, '0},
        '{bmhq_pkg::OP_INSERT, 16'd100,  1'b0, '0},
        '{bmhq_pkg::OP_INSERT, 16'd99,   1'b0, '0},
        '{bmhq_pkg::OP_DELETE, 16'h0000, 1'b0, '0},
        '{bmhq_pkg::OP_DELETE, 16'h0000, 1'b0, '0},
        '{bmhq_pkg::OP_DELETE, 16'h0000, 1'b0, '0},
        '{bmhq_pkg::OP_DELETE, 16'h0000, 1'b1,
          '{bmhq_pkg::EMPTY_MARK, bmhq_pkg::STS_EMPTY, 8'd0, 1'b1, 1'b0}}
    };

    binary_min_heap_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Apply one operation to the behavioral heap and return its result
    function automatic t_heap_result predict_heap_op(input bmhq_pkg::t_opcode op,
                                                     input logic [15:0] raw);
        t_heap_result       r;
        logic signed [15:0] v;
        logic signed [15:0] top;
        logic signed [15:0] last;
        int                 pos;
        int                 kid;
        bit                 settled;
        v = $signed(raw);
        r = '0;
        r.status = bmhq_pkg::STS_OK;
        case (op)
            bmhq_pkg::OP_INSERT: begin
                if (held_count >= capacity_model) begin
                    r.status = bmhq_pkg::STS_FULL;
                end else begin
                    // sift the new value up past every larger parent
                    held_count++;
                    pos = held_count;
                    while (pos > 1 && heap_model[pos / 2] > v) begin
                        heap_model[pos] = heap_model[pos / 2];
                        pos = pos / 2;
                    end
                    heap_model[pos] = v;
                end
            end
            bmhq_pkg::OP_DELETE, bmhq_pkg::OP_PEEK: begin
                if (held_count == 0) begin
                    r.rvalue = bmhq_pkg::EMPTY_MARK;
                    r.status = bmhq_pkg::STS_EMPTY;
                end else if (op == bmhq_pkg::OP_PEEK) begin
                    r.rvalue = heap_model[1];
                end else begin
                    // remove the root, sift the old last entry down
                    top = heap_model[1];
                    last = heap_model[held_count];
                    held_count--;
                    pos = 1;
                    settled = 1'b0;
                    while (!settled && pos * 2 <= held_count) begin
                        kid = pos * 2;
                        if (kid != held_count && heap_model[kid + 1] < heap_model[kid]) begin
                            kid++;
                        end
                        if (last > heap_model[kid]) begin
                            heap_model[pos] = heap_model[kid];
                            pos = kid;
                        end else begin
                            settled = 1'b1;
                        end
                    end
                    heap_model[pos] = last;
                    r.rvalue = top;
                end
            end
            default: begin
                held_count = 0;
            end
        endcase
        r.count    = held_count[7:0];
        r.is_empty = (held_count == 0);
        r.is_full  = (held_count >= capacity_model);
        return r;
    endfunction

    function automatic bmhq_pkg::t_opcode pick_op(input int ins_pct, input int clr_pct);
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < clr_pct) begin
            return bmhq_pkg::OP_CLEAR;
        end else if (roll < clr_pct + ins_pct) begin
            return bmhq_pkg::OP_INSERT;
        end else if ($urandom_range(0, 9) < 7) begin
            return bmhq_pkg::OP_DELETE;
        end
        return bmhq_pkg::OP_PEEK;
    endfunction

    // Mostly full-range values, some extremes, some narrow spread for ties
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h8001;
                    2: return 16'h7FFF;
                    default: return 16'h0000;
                endcase
            end
            1, 2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // Drive one item, wait for it to be taken, then record what it should give
    task automatic send_op(input bmhq_pkg::t_opcode op, input logic [15:0] val,
                           input logic typed, input t_heap_result want);
        t_heap_result pred;
        int           gap;
        if (!no_idle && burst_left == 0) begin
            gap = int'($urandom_range(1, 12));
            burst_left = int'($urandom_range(1, 40));
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= val;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_heap_op(op, val);
        expected_replies.push_back(typed ? want : pred);
    endtask

    // Hold the sender until every outstanding result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [7:0] cap_val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {24'd0, cap_val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        capacity_model = int'(cap_val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input int cap, input int n, input int ins_pct,
                             input int clr_pct);
        drain_results();
        write_capacity(8'(cap));
        no_idle = ($urandom_range(0, 3) == 0);
        burst_left = 0;
        repeat (n) send_op(pick_op(ins_pct, clr_pct), pick_value(), 1'b0, '0);
    endtask

    // Receiver: stall in a randomly chosen mode that is changed on a random timer
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            case (rx_mode)
                1: if ($urandom_range(0, 99) < 40) stall_left <= int'($urandom_range(1, 3));
                2: if ($urandom_range(0, 99) < 10) stall_left <= int'($urandom_range(5, 25));
                default: ;
            endcase
        end
        if (rx_timer == 0) begin
            rx_mode <= int'($urandom_range(0, 2));
            rx_timer <= int'($urandom_range(50, 400));
        end else begin
            rx_timer <= rx_timer - 1;
        end
    end

    // Check each taken result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_heap_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_replies.size() == 0) begin
                $error("result with no item pending: tdata=%h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                if (m_axis_tdata[15:0] !== want.rvalue) begin
                    $error("result_value mismatch: expected %h, got %h",
                           want.rvalue, m_axis_tdata[15:0]);
                    error_count++;
                end
                if (m_axis_tdata[17:16] !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, m_axis_tdata[17:16]);
                    error_count++;
                end
                if (m_axis_tdata[25:18] !== want.count) begin
                    $error("count mismatch: expected %0d, got %0d",
                           want.count, m_axis_tdata[25:18]);
                    error_count++;
                end
                if (m_axis_tdata[26] !== want.is_empty) begin
                    $error("is_empty mismatch: expected %0d, got %0d",
                           want.is_empty, m_axis_tdata[26]);
                    error_count++;
                end
                if (m_axis_tdata[27] !== want.is_full) begin
                    $error("is_full mismatch: expected %0d, got %0d",
                           want.is_full, m_axis_tdata[27]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at the reset capacity
        for (int i = 0; i < DIR_N; i++) begin
            send_op(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
        end

        // zero capacity: every insert refused, empty and full together
        run_phase(0, 30, 70, 2);
        // small capacity, filled past its limit
        run_phase(10, 120, 65, 2);
        // largest capacity, filled to the top
        run_phase(255, 300, 95, 0);
        // capacity lowered far below the count held
        run_phase(10, 100, 50, 0);
        run_phase(1, 60, 50, 3);
        for (int p = 0; p < 8; p++) begin
            run_phase(int'($urandom_range(0, 255)), 130,
                      int'($urandom_range(35, 75)), 3);
        end

        drain_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
